// ===== rtl/cstess_pkg.sv =====
// Shared types and constants of the cardinal spline tessellator.
`timescale 1ns / 1ps
package cstess_pkg;

  // Input action codes.
  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_END = 1'b1;

  // Tension register reset value, 0.5 in Q0.8.
  localparam logic [7:0] TENSION_RST = 8'd128;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } point_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CTRL,
    ST_EMIT
  } ctrl_state_e;

  // Which window entries form the segment a, b, c, d.
  typedef enum logic [1:0] {
    SEG_FIRST,  // w0, w0, w1, new point
    SEG_MID,    // w0, w1, w2, new point
    SEG_END     // w0, w1, w2, w2
  } seg_sel_e;

  typedef enum logic [1:0] {
    WIN_NONE,
    WIN_WRITE,
    WIN_SHIFT
  } win_op_e;

  // Inner control point coordinates.
  typedef enum logic [1:0] {
    CP_UX,
    CP_UY,
    CP_VX,
    CP_VY
  } cp_sel_e;

  typedef struct packed {
    logic      load_seg;
    seg_sel_e  seg_sel;
    win_op_e   win_op;
    logic [1:0] win_idx;
    logic      cp_a_en;
    cp_sel_e   cp_a_idx;
    logic      cp_b_en;
    cp_sel_e   cp_b_idx;
    logic      issue;
    logic      last;
  } dp_cmd_t;

endpackage

// ===== rtl/cstess_in_if.sv =====
// Request channel carrying polyline points and end actions.
`timescale 1ns / 1ps
interface cstess_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [15:0] x_in;
  logic signed [15:0] y_in;

  modport source (output valid, output action, output x_in, output y_in, input ready);
  modport sink (input valid, input action, input x_in, input y_in, output ready);
endinterface

// ===== rtl/cstess_out_if.sv =====
// Output channel carrying tessellated curve vertices.
`timescale 1ns / 1ps
interface cstess_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_out;
  logic signed [15:0] y_out;
  logic               last_of_run;

  modport source (output valid, output x_out, output y_out, output last_of_run, input ready);
  modport sink (input valid, input x_out, input y_out, input last_of_run, output ready);
endinterface

// ===== rtl/cardinal_spline_bezier_tessellator_top.sv =====
// Top level of the cardinal spline to cubic Bezier tessellator.
`timescale 1ns / 1ps
//
//  Channel   Direction  Payload                       Handshake
//  cfg       in         cfg_wdata_i (tension, Q0.8)   cfg_we_i, no stall
//  in_i      in         action, x_in, y_in            valid / ready
//  out_o     out        x_out, y_out, last_of_run     valid / ready
//
// A request that only stores a point, or ends a polyline of fewer than two
// points, is taken without leaving the idle state. A request that yields a
// segment is accepted, the shared control point unit forms the four inner
// control point coordinates, then one vertex per cycle goes through the
// weight multipliers while the output is not stalled; a two-point end yields
// its two vertices after the same setup. Vertices pass the products and the
// output registers. A stalled output freezes the whole vertex pipeline; the
// request side is blocked only while a segment is being produced. Reset
// empties the pipeline, clears the point count and sets tension to 0.5.
module cardinal_spline_bezier_tessellator_top #(
  parameter int SEGMENT_STEPS = 50
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  cstess_in_if.sink   in_i,
  cstess_out_if.source out_o
);

  localparam int KW = $clog2(SEGMENT_STEPS + 1);

  cstess_pkg::dp_cmd_t cmd;
  logic [KW-1:0]       k;
  logic                pipe_en;

  // The controller owns the point count and sequencing; the datapath holds
  // every coordinate and arithmetic unit.
  cstess_ctrl #(
    .SEGMENT_STEPS(SEGMENT_STEPS),
    .KW           (KW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .action_i  (in_i.action),
    .pipe_en_i (pipe_en),
    .cmd_o     (cmd),
    .k_o       (k)
  );

  cstess_dp #(
    .SEGMENT_STEPS(SEGMENT_STEPS),
    .KW           (KW)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .x_i        (in_i.x_in),
    .y_i        (in_i.y_in),
    .cmd_i      (cmd),
    .k_i        (k),
    .pipe_en_o  (pipe_en),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .x_o        (out_o.x_out),
    .y_o        (out_o.y_out),
    .last_o     (out_o.last_of_run)
  );

`ifndef ASSERT_OFF
  // A vertex never enters the pipeline while it is stalled.
  a_issue_when_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> pipe_en) else $error("vertex issued into stalled pipeline");

  // New requests are never taken while a segment is still being issued.
  a_no_accept_during_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> !cmd.issue) else $error("request taken mid-segment");

  // Segment points are only captured on an accepted request.
  a_seg_load_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_seg |-> (in_i.valid && in_i.ready)) else $error("segment load without request");

  // After the final vertex of a run is issued, issuing stops.
  a_stop_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.issue && cmd.last) |=> !cmd.issue) else $error("vertex issued after last");
`endif

endmodule

// ===== rtl/cstess_dp.sv =====
// Datapath: point window, control point unit, vertex pipeline and output register.
`timescale 1ns / 1ps
module cstess_dp #(
  parameter int SEGMENT_STEPS = 50,
  parameter int KW = $clog2(SEGMENT_STEPS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [7:0]            cfg_wdata_i,
  input  logic signed [15:0]    x_i,
  input  logic signed [15:0]    y_i,
  input  cstess_pkg::dp_cmd_t   cmd_i,
  input  logic [KW-1:0]         k_i,
  output logic                  pipe_en_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [15:0]    x_o,
  output logic signed [15:0]    y_o,
  output logic                  last_o
);

  localparam logic [63:0] SS  = 64'(SEGMENT_STEPS);
  localparam logic [63:0] DEN = SS * SS * SS;

  // Bernstein weights in Q1.16, one entry per step.
  logic [16:0] w0_tab [SEGMENT_STEPS+1];
  logic [16:0] w1_tab [SEGMENT_STEPS+1];
  logic [16:0] w2_tab [SEGMENT_STEPS+1];
  logic [16:0] w3_tab [SEGMENT_STEPS+1];

  for (genvar k = 0; k <= SEGMENT_STEPS; k++) begin : gen_wt
    localparam logic [63:0] SK = 64'(SEGMENT_STEPS - k);
    localparam logic [63:0] KK = 64'(k);
    localparam logic [63:0] W0 = (SK * SK * SK * 64'd65536 + DEN / 64'd2) / DEN;
    localparam logic [63:0] W1 = (64'd3 * SK * SK * KK * 64'd65536 + DEN / 64'd2) / DEN;
    localparam logic [63:0] W2 = (64'd3 * SK * KK * KK * 64'd65536 + DEN / 64'd2) / DEN;
    localparam logic [63:0] W3 = (KK * KK * KK * 64'd65536 + DEN / 64'd2) / DEN;
    assign w0_tab[k] = W0[16:0];
    assign w1_tab[k] = W1[16:0];
    assign w2_tab[k] = W2[16:0];
    assign w3_tab[k] = W3[16:0];
  end

  function automatic logic signed [15:0] round_sat(input logic signed [37:0] s);
    logic signed [37:0] r;
    r = (s + 38'sd32768) >>> 16;
    if (r > 38'sd32767) begin
      return 16'sh7fff;
    end else if (r < -38'sd32768) begin
      return -16'sh8000;
    end
    return r[15:0];
  endfunction

  logic [7:0]            tension_q;
  cstess_pkg::point_t    win_q [3];
  cstess_pkg::point_t    seg_a_q, seg_b_q, seg_c_q, seg_d_q;
  cstess_pkg::point_t    in_pt;
  logic signed [17:0]    cp_q [4];
  logic signed [25:0]    prod_q;
  logic signed [15:0]    base_q;

  assign in_pt.x = x_i;
  assign in_pt.y = y_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tension_q <= cstess_pkg::TENSION_RST;
    end else if (cfg_we_i) begin
      tension_q <= cfg_wdata_i;
    end
  end

  // Point window and segment capture.
  always_ff @(posedge clk_i) begin
    case (cmd_i.win_op)
      cstess_pkg::WIN_WRITE: win_q[cmd_i.win_idx] <= in_pt;
      cstess_pkg::WIN_SHIFT: begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
        win_q[2] <= in_pt;
      end
      default: ;
    endcase
    if (cmd_i.load_seg) begin
      case (cmd_i.seg_sel)
        cstess_pkg::SEG_FIRST: begin
          seg_a_q <= win_q[0];
          seg_b_q <= win_q[0];
          seg_c_q <= win_q[1];
          seg_d_q <= in_pt;
        end
        cstess_pkg::SEG_MID: begin
          seg_a_q <= win_q[0];
          seg_b_q <= win_q[1];
          seg_c_q <= win_q[2];
          seg_d_q <= in_pt;
        end
        default: begin
          seg_a_q <= win_q[0];
          seg_b_q <= win_q[1];
          seg_c_q <= win_q[2];
          seg_d_q <= win_q[2];
        end
      endcase
    end
  end

  // Control point unit: the first step registers diff * tension, the second divides by
  // 768 with rounding (shift by 256, then exact divide by 3 via reciprocal).
  logic signed [16:0] cp_diff;
  logic signed [15:0] cp_base;
  logic signed [25:0] cp_prod;

  always_comb begin
    case (cmd_i.cp_a_idx)
      cstess_pkg::CP_UX: begin
        cp_diff = 17'(seg_c_q.x) - 17'(seg_a_q.x);
        cp_base = seg_b_q.x;
      end
      cstess_pkg::CP_UY: begin
        cp_diff = 17'(seg_c_q.y) - 17'(seg_a_q.y);
        cp_base = seg_b_q.y;
      end
      cstess_pkg::CP_VX: begin
        cp_diff = 17'(seg_b_q.x) - 17'(seg_d_q.x);
        cp_base = seg_c_q.x;
      end
      default: begin
        cp_diff = 17'(seg_b_q.y) - 17'(seg_d_q.y);
        cp_base = seg_c_q.y;
      end
    endcase
  end

  assign cp_prod = 26'(cp_diff) * 26'($signed({1'b0, tension_q}));

  logic signed [17:0] div_m;
  logic               div_neg;
  logic signed [17:0] div_mag;
  logic [32:0]        div_prod;
  logic [15:0]        div_q;
  logic signed [17:0] div_qs;
  logic signed [17:0] cp_res;
  logic signed [25:0] prod_rnd;

  assign prod_rnd = (prod_q + 26'sd384) >>> 8;
  assign div_m    = prod_rnd[17:0];
  assign div_neg  = div_m[17];
  // floor(m/3) for negative m is -floor((-m + 2)/3).
  assign div_mag  = div_neg ? (18'sd2 - div_m) : div_m;
  assign div_prod = {16'b0, div_mag[16:0]} * 33'd43691;
  assign div_q    = div_prod[32:17];
  assign div_qs   = div_neg ? -$signed({2'b0, div_q}) : $signed({2'b0, div_q});
  assign cp_res   = 18'(base_q) + div_qs;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cp_a_en) begin
      prod_q <= cp_prod;
      base_q <= cp_base;
    end
    if (cmd_i.cp_b_en) begin
      cp_q[cmd_i.cp_b_idx] <= cp_res;
    end
  end

  // Vertex pipeline: products stage, then sum, round and saturate into the
  // output register. All stages stall together when the output is held.
  logic               s1_valid_q;
  logic               s1_last_q;
  logic signed [35:0] px_q [4];
  logic signed [35:0] py_q [4];
  logic               out_valid_q;
  logic               out_last_q;
  logic signed [15:0] out_x_q, out_y_q;
  logic               pipe_en;

  logic signed [35:0] w_s [4];
  logic signed [35:0] vx [4];
  logic signed [35:0] vy [4];

  assign pipe_en = !out_valid_q || out_ready_i;

  assign w_s[0] = 36'($signed({1'b0, w0_tab[k_i]}));
  assign w_s[1] = 36'($signed({1'b0, w1_tab[k_i]}));
  assign w_s[2] = 36'($signed({1'b0, w2_tab[k_i]}));
  assign w_s[3] = 36'($signed({1'b0, w3_tab[k_i]}));
  assign vx[0]  = 36'(seg_b_q.x);
  assign vx[1]  = 36'(cp_q[cstess_pkg::CP_UX]);
  assign vx[2]  = 36'(cp_q[cstess_pkg::CP_VX]);
  assign vx[3]  = 36'(seg_c_q.x);
  assign vy[0]  = 36'(seg_b_q.y);
  assign vy[1]  = 36'(cp_q[cstess_pkg::CP_UY]);
  assign vy[2]  = 36'(cp_q[cstess_pkg::CP_VY]);
  assign vy[3]  = 36'(seg_c_q.y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_q  <= cmd_i.issue;
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en && cmd_i.issue) begin
      for (int i = 0; i < 4; i++) begin
        px_q[i] <= w_s[i] * vx[i];
        py_q[i] <= w_s[i] * vy[i];
      end
      s1_last_q <= cmd_i.last;
    end
    if (pipe_en && s1_valid_q) begin
      out_x_q    <= round_sat(38'(px_q[0]) + 38'(px_q[1]) + 38'(px_q[2]) + 38'(px_q[3]));
      out_y_q    <= round_sat(38'(py_q[0]) + 38'(py_q[1]) + 38'(py_q[2]) + 38'(py_q[3]));
      out_last_q <= s1_last_q;
    end
  end

  assign pipe_en_o   = pipe_en;
  assign out_valid_o = out_valid_q;
  assign x_o         = out_x_q;
  assign y_o         = out_y_q;
  assign last_o      = out_last_q;

endmodule

// ===== rtl/cstess_ctrl.sv =====
// Controller: point count, request decode and vertex step sequencing.
`timescale 1ns / 1ps
module cstess_ctrl #(
  parameter int SEGMENT_STEPS = 50,
  parameter int KW = $clog2(SEGMENT_STEPS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 action_i,
  input  logic                 pipe_en_i,
  output cstess_pkg::dp_cmd_t  cmd_o,
  output logic [KW-1:0]        k_o
);

  localparam logic [KW-1:0] K_LAST = KW'(SEGMENT_STEPS);

  cstess_pkg::ctrl_state_e state_q, state_d;
  logic [1:0]    count_q, count_d;
  logic [2:0]    cnt_q, cnt_d;
  logic [KW-1:0] k_q, k_d;
  logic          line_q, line_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cstess_pkg::ST_IDLE;
      count_q <= 2'd0;
      cnt_q   <= 3'd0;
      k_q     <= '0;
      line_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      line_q  <= line_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    line_d     = line_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.seg_sel  = cstess_pkg::SEG_FIRST;
    cmd_o.win_op   = cstess_pkg::WIN_NONE;
    cmd_o.cp_a_idx = cstess_pkg::cp_sel_e'(cnt_q[1:0]);
    cmd_o.cp_b_idx = cstess_pkg::cp_sel_e'(2'(cnt_q - 3'd1));
    case (state_q)
      cstess_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cnt_d      = 3'd0;
        k_d        = '0;
        if (in_valid_i) begin
          if (action_i == cstess_pkg::ACT_ADD) begin
            if (count_q == 2'd3) begin
              cmd_o.load_seg = 1'b1;
              cmd_o.seg_sel  = cstess_pkg::SEG_MID;
              cmd_o.win_op   = cstess_pkg::WIN_SHIFT;
              line_d         = 1'b0;
              state_d        = cstess_pkg::ST_CTRL;
            end else begin
              cmd_o.win_op  = cstess_pkg::WIN_WRITE;
              cmd_o.win_idx = count_q;
              count_d       = count_q + 2'd1;
              if (count_q == 2'd2) begin
                cmd_o.load_seg = 1'b1;
                cmd_o.seg_sel  = cstess_pkg::SEG_FIRST;
                line_d         = 1'b0;
                state_d        = cstess_pkg::ST_CTRL;
              end
            end
          end else begin
            count_d = 2'd0;
            if (count_q == 2'd3) begin
              cmd_o.load_seg = 1'b1;
              cmd_o.seg_sel  = cstess_pkg::SEG_END;
              line_d         = 1'b0;
              state_d        = cstess_pkg::ST_CTRL;
            end else if (count_q == 2'd2) begin
              // Straight line: b and c are the two points, only the end steps run.
              cmd_o.load_seg = 1'b1;
              cmd_o.seg_sel  = cstess_pkg::SEG_FIRST;
              line_d         = 1'b1;
              state_d        = cstess_pkg::ST_CTRL;
            end
          end
        end
      end
      cstess_pkg::ST_CTRL: begin
        cmd_o.cp_a_en = (cnt_q != 3'd4);
        cmd_o.cp_b_en = (cnt_q != 3'd0);
        cnt_d         = cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          state_d = cstess_pkg::ST_EMIT;
        end
      end
      cstess_pkg::ST_EMIT: begin
        cmd_o.issue = pipe_en_i;
        cmd_o.last  = (k_q == K_LAST);
        if (pipe_en_i) begin
          if (k_q == K_LAST) begin
            state_d = cstess_pkg::ST_IDLE;
          end else if (line_q) begin
            k_d = K_LAST;
          end else begin
            k_d = k_q + KW'(1);
          end
        end
      end
      default: begin
        state_d = cstess_pkg::ST_IDLE;
      end
    endcase
  end

  assign k_o = k_q;

endmodule

// ===== test/tb_cardinal_spline_bezier_tessellator_top.sv =====
// Self-checking testbench of the cardinal spline to cubic Bezier tessellator.
`timescale 1ns / 1ps
module tb_cardinal_spline_bezier_tessellator_top;

  // Vertices per segment minus one. The testbench uses the block's default.
  localparam int SEG_STEPS = 50;
  // Cycles to let pass after the last expected vertex before touching the
  // tension register. This is longer than a whole segment with its output
  // delay, so it covers any request still inside the block.
  localparam int DRAIN_CYCLES = SEG_STEPS + 20;
  // Random polyline phases after the directed part, and requests in each.
  localparam int NUM_PHASES = 8;
  localparam int PHASE_REQUESTS = 55;
  // Length of the one long hold-off on the vertex side.
  localparam int HOLD_OFF_CYCLES = 400;

  // A point with room for control points that leave the 16-bit range.
  typedef struct {
    longint x;
    longint y;
  } coord_t;

  typedef struct packed {
    logic               action;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } request_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
  } vertex_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  cstess_in_if  req_if ();
  cstess_out_if vtx_if ();

  cardinal_spline_bezier_tessellator_top #(
    .SEGMENT_STEPS(SEG_STEPS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (req_if),
    .out_o      (vtx_if)
  );

  // Requests waiting to be offered, and vertices the block still owes us.
  request_t request_q [$];
  vertex_t  vertex_q [$];

  // Our own copy of the block's state: the last three points, how many of
  // them are valid, and the tension that the register holds.
  coord_t      pt_win [3];
  int unsigned pt_cnt;
  logic [7:0]  tension_q;

  // Handshake bookkeeping shared between the edge-triggered processes.
  // A flag set at the rising edge is consumed at the following falling edge.
  bit       req_taken;
  bit       vtx_taken;
  bit       offering;
  request_t cur_req;
  int       gap_left;
  int       stall_left;
  int       hold_left;
  bit       send_gaps;
  bit       recv_stalls;
  int       err_cnt;

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Divide and round half toward plus infinity; d is always positive here.
  function automatic longint round_div(longint n, longint d);
    longint m;
    longint q;
    m = n + d / 2;
    q = m / d;
    if ((m % d) != 0 && m < 0) q--;
    return q;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic void queue_vertex(longint x, longint y, logic last);
    vertex_t v;
    v.x = clamp16(x);
    v.y = clamp16(y);
    v.last = last;
    vertex_q = {vertex_q, v};
  endfunction

  // Segment b -> c with neighbours a and d. The inner control points pull
  // along the neighbour difference scaled by tension / 3, where the tension
  // is Q0.8, hence the division by 768. The Bernstein weights are rounded to
  // Q1.16 before the weighted sum, exactly as the datapath quantizes them.
  function automatic void queue_segment(coord_t a, coord_t b, coord_t c, coord_t d);
    coord_t u;
    coord_t v;
    longint t;
    longint den;
    longint s;
    longint w0;
    longint w1;
    longint w2;
    longint w3;
    t = longint'(tension_q);
    u.x = b.x + round_div((c.x - a.x) * t, 768);
    u.y = b.y + round_div((c.y - a.y) * t, 768);
    v.x = c.x + round_div((b.x - d.x) * t, 768);
    v.y = c.y + round_div((b.y - d.y) * t, 768);
    den = longint'(SEG_STEPS) * SEG_STEPS * SEG_STEPS;
    for (longint k = 0; k <= SEG_STEPS; k++) begin
      s = SEG_STEPS - k;
      w0 = round_div(s * s * s * 65536, den);
      w1 = round_div(3 * s * s * k * 65536, den);
      w2 = round_div(3 * s * k * k * 65536, den);
      w3 = round_div(k * k * k * 65536, den);
      queue_vertex(round_div(w0 * b.x + w1 * u.x + w2 * v.x + w3 * c.x, 65536),
                   round_div(w0 * b.y + w1 * u.y + w2 * v.y + w3 * c.y, 65536),
                   k == SEG_STEPS);
    end
  endfunction

  // Update our state for one accepted request and queue what it yields.
  function automatic void predict_request(request_t r);
    coord_t p;
    p.x = r.x;
    p.y = r.y;
    if (r.action == cstess_pkg::ACT_ADD) begin
      if (pt_cnt < 2) begin
        pt_win[pt_cnt] = p;
        pt_cnt++;
      end else if (pt_cnt == 2) begin
        // First segment: the start point stands in for its missing neighbour.
        queue_segment(pt_win[0], pt_win[0], pt_win[1], p);
        pt_win[2] = p;
        pt_cnt = 3;
      end else begin
        queue_segment(pt_win[0], pt_win[1], pt_win[2], p);
        pt_win[0] = pt_win[1];
        pt_win[1] = pt_win[2];
        pt_win[2] = p;
      end
    end else begin
      if (pt_cnt == 2) begin
        // Two points only: a straight line of exactly two vertices.
        queue_vertex(pt_win[0].x, pt_win[0].y, 1'b0);
        queue_vertex(pt_win[1].x, pt_win[1].y, 1'b1);
      end else if (pt_cnt == 3) begin
        // Closing segment: the end point repeats as its own neighbour.
        queue_segment(pt_win[0], pt_win[1], pt_win[2], pt_win[2]);
      end
      pt_cnt = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // A request is taken at a rising edge with valid and ready both high; the
  // expectation is formed from the payload the block saw at that edge.
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      predict_request('{req_if.action, req_if.x_in, req_if.y_in});
      req_taken = 1'b1;
    end
  end

  // The sender changes its outputs only at the falling edge. After each taken
  // request it draws a gap before the next one, unless gaps are switched off
  // for the phase. valid gets one nonblocking assignment per edge, so a
  // back-to-back request keeps it high without a glitch.
  always @(negedge clk_i) begin : drive_requests
    logic next_valid;
    next_valid = req_if.valid;
    if (req_taken) begin
      req_taken = 1'b0;
      offering = 1'b0;
      next_valid = 1'b0;
      gap_left = send_gaps ? $urandom_range(0, 10) : 0;
    end
    if (!offering && rst_ni) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (request_q.size() != 0) begin
        cur_req = request_q.pop_front();
        req_if.action <= cur_req.action;
        req_if.x_in <= cur_req.x;
        req_if.y_in <= cur_req.y;
        next_valid = 1'b1;
        offering = 1'b1;
      end
    end
    req_if.valid <= next_valid;
  end

  // ---------------------------------------------------------------------------
  // Vertex side
  // ---------------------------------------------------------------------------

  // Each taken vertex is compared field by field against the oldest
  // expectation. A vertex with nothing expected is a failure as well.
  always @(posedge clk_i) begin : check_vertices
    vertex_t want;
    if (rst_ni && vtx_if.valid && vtx_if.ready) begin
      vtx_taken = 1'b1;
      if (vertex_q.size() == 0) begin
        err_cnt++;
        $error("vertex (%0d, %0d) last %0b arrived with none expected",
               vtx_if.x_out, vtx_if.y_out, vtx_if.last_of_run);
      end else begin
        want = vertex_q.pop_front();
        if (vtx_if.x_out !== want.x) begin
          err_cnt++;
          $error("x_out: expected %0d, got %0d", want.x, vtx_if.x_out);
        end
        if (vtx_if.y_out !== want.y) begin
          err_cnt++;
          $error("y_out: expected %0d, got %0d", want.y, vtx_if.y_out);
        end
        if (vtx_if.last_of_run !== want.last) begin
          err_cnt++;
          $error("last_of_run: expected %0b, got %0b", want.last, vtx_if.last_of_run);
        end
      end
    end
  end

  // The receiver stalls for a random count after each taken vertex. The long
  // hold-off is counted down here as well; while it lasts the vertex pipeline
  // freezes and, once a segment is under way, the block stops taking requests.
  always @(negedge clk_i) begin : drive_ready
    logic next_ready;
    if (vtx_taken) begin
      vtx_taken = 1'b0;
      stall_left = recv_stalls ? $urandom_range(0, 10) : 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      next_ready = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      next_ready = 1'b0;
    end else begin
      next_ready = 1'b1;
    end
    vtx_if.ready <= next_ready;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic void push_add(int x, int y);
    request_t r;
    r = '{cstess_pkg::ACT_ADD, 16'(x), 16'(y)};
    request_q = {request_q, r};
  endfunction

  // The coordinates of an end request are ignored, so they get random bits.
  function automatic void push_end();
    request_t r;
    r = '{cstess_pkg::ACT_END, 16'($urandom), 16'($urandom)};
    request_q = {request_q, r};
  endfunction

  // Mostly points in a moderate window, some anywhere in the full range, and
  // now and then a corner value to drive the saturation.
  function automatic int rand_coord();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom_range(0, 1) ? 32767 : -32768;
    if (sel < 4) return int'(16'sh0000 + $signed(16'($urandom)));
    return int'($urandom_range(0, 8191)) - 4096;
  endfunction

  // Queue random polylines until about n requests are queued. Most are
  // well-formed with three or more points; the rest are short polylines
  // of zero to two points and stray extra end requests.
  task automatic queue_polylines(input int n);
    int queued;
    int len;
    int unsigned pick;
    queued = 0;
    while (queued < n) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) len = pick;
      else if (pick < 4) len = 2;
      else len = $urandom_range(3, 8);
      for (int i = 0; i < len; i++) push_add(rand_coord(), rand_coord());
      push_end();
      queued += len + 1;
      if ($urandom_range(0, 9) == 0) begin
        push_end();
        queued++;
      end
    end
  endtask

  // Wait until every request has been taken and every vertex has arrived,
  // then give a request that yields nothing time to leave the block.
  task automatic settle();
    while (request_q.size() != 0 || offering || vertex_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Only called with the block idle, so the model may take the new value at once.
  task automatic write_tension(input logic [7:0] value);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    tension_q = value;
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 8'd0;
    req_if.valid = 1'b0;
    req_if.action = cstess_pkg::ACT_ADD;
    req_if.x_in = 16'sd0;
    req_if.y_in = 16'sd0;
    vtx_if.ready = 1'b0;
    pt_cnt = 0;
    foreach (pt_win[i]) pt_win[i] = '{0, 0};
    tension_q = cstess_pkg::TENSION_RST;
    err_cnt = 0;
    gap_left = 0;
    stall_left = 0;
    hold_left = 0;
    send_gaps = 1'b1;
    recv_stalls = 1'b1;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset tension of one half. An end with no points
    // and an end with one point yield nothing; two opposite corners and an
    // end give the straight two-vertex line.
    push_end();
    push_add(32767, -32768);
    push_end();
    push_add(-32768, 32767);
    push_add(32767, -32768);
    push_end();
    settle();

    // Full tension with corner points: first segment, middle segments and
    // the closing segment, with control points far outside the range so
    // that the vertices saturate.
    write_tension(8'd255);
    push_add(-32768, -32768);
    push_add(32767, 32767);
    push_add(-32768, 32767);
    push_add(32767, -32768);
    push_add(0, 0);
    push_end();
    settle();

    // Zero tension turns each segment into a straight run. Three points then
    // an end exercise the closing segment right after the first one, and a
    // second end finds the window empty.
    write_tension(8'd0);
    push_add(-1, -1);
    push_add(16, -16);
    push_add(4096, 100);
    push_end();
    push_end();
    settle();

    // Random phases, each at its own tension and idle pattern. The second
    // phase runs with no idling on either side and starts with the long
    // receiver hold-off, so that the sender keeps offering into a stalled block.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: write_tension(8'd1);
        1: write_tension(8'd200);
        2: write_tension(cstess_pkg::TENSION_RST);
        4: write_tension(8'd255);
        5: write_tension(8'd0);
        default: write_tension(8'($urandom_range(0, 255)));
      endcase
      send_gaps = (ph % 4 == 0) || (ph % 4 == 2);
      recv_stalls = (ph % 4 == 0) || (ph % 4 == 3);
      if (ph == 1) begin
        @(posedge clk_i);
        hold_left = HOLD_OFF_CYCLES;
      end
      queue_polylines(PHASE_REQUESTS);
      settle();
    end

    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a vertex that never comes ends the run here.
  // The slowest correct run, every request followed by a full segment that
  // waits out the longest stall per vertex, stays well below this.
  initial begin
    #10ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
